// ----- hw/rtl/rvba_pkg.sv -----
package rvba_pkg;

    // Stream payload layout
    localparam int unsigned S_TDATA_W = 144;
    localparam int unsigned M_TDATA_W = 64;
    localparam int unsigned COORD_W   = 21;
    localparam int unsigned DIFF_W    = 22;
    localparam int unsigned FLUX_W    = 16;
    localparam int unsigned OPL_W     = 32;
    localparam int unsigned LAM_W     = 16;
    localparam int unsigned VADDR_W   = 12;
    localparam int unsigned DIM_W     = 7;
    localparam int unsigned INT_W     = 63;

    localparam int unsigned POS_X_LO  = 0;
    localparam int unsigned POS_Y_LO  = 21;
    localparam int unsigned POS_Z_LO  = 42;
    localparam int unsigned FLUX_LO   = 63;
    localparam int unsigned OPL_LO    = 79;
    localparam int unsigned LAM_LO    = 111;
    localparam int unsigned VADDR_LO  = 127;

    // Shared multiplier operands and product
    localparam int unsigned MUL_W     = 33;
    localparam int unsigned PROD_W    = 66;

    // CORDIC datapath
    localparam int unsigned CORD_W      = 34;
    localparam int unsigned ANGLE_COUNT = 24;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORD_W-1:0] HALF_TURN    = 34'sd2147483648;

    localparam logic [INT_W-1:0] OUT_MAX = '1;

    // Function codes carried in s_tuser
    localparam logic [1:0] FUNC_RAY   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [1:0] MODE_INCOH = 2'd0;
    localparam logic [1:0] MODE_COH   = 2'd1;

    // Register indexes (byte address / 8)
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_DIMS   = 3'd1;
    localparam logic [2:0] REG_OFFSET = 3'd2;
    localparam logic [2:0] REG_ROW_X  = 3'd3;
    localparam logic [2:0] REG_ROW_Y  = 3'd4;
    localparam logic [2:0] REG_ROW_Z  = 3'd5;

    typedef logic signed [CORD_W-1:0] cord_t;
    typedef logic signed [MUL_W-1:0]  mul_op_t;

    // Arctangent of 2^-i in Q0.32 turns.
    function automatic logic [31:0] angle_turns(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ----- hw/rtl/rvba_div.sv -----
module rvba_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [rvba_pkg::OPL_W-1:0] dividend,
    input  logic [rvba_pkg::LAM_W-1:0] divisor,
    output logic                     done,
    output logic [31:0]              quotient
);
    import rvba_pkg::*;

    // Long division of {dividend, 32 zeros} by divisor, two bits a cycle.
    // The low 32 quotient bits equal ((dividend mod divisor) << 32) / divisor.
    logic [63:0]      num_reg;
    logic [LAM_W-1:0] rem_reg;
    logic [LAM_W-1:0] lam_reg;
    logic [31:0]      quo_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             zero_reg;

    logic [LAM_W:0]   r1, r2;
    logic             q1, q2;

    always_comb begin
        r1 = {rem_reg, num_reg[63]};
        q1 = (r1 >= {1'b0, lam_reg});
        if (q1) begin
            r1 = r1 - {1'b0, lam_reg};
        end
        r2 = {r1[LAM_W-1:0], num_reg[62]};
        q2 = (r2 >= {1'b0, lam_reg});
        if (q2) begin
            r2 = r2 - {1'b0, lam_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= {dividend, 32'd0};
            rem_reg  <= '0;
            lam_reg  <= divisor;
            zero_reg <= (divisor == '0);
            quo_reg  <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[61:0], 2'b00};
            rem_reg <= r2[LAM_W-1:0];
            quo_reg <= {quo_reg[29:0], q1, q2};
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? 32'd0 : quo_reg;

endmodule

// ----- hw/rtl/rvba_cordic.sv -----
module rvba_cordic #(
    parameter int unsigned STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [31:0]         phase,
    output logic                done,
    output rvba_pkg::cord_t     cos_o,
    output rvba_pkg::cord_t     sin_o
);
    import rvba_pkg::*;

    localparam logic [4:0] LAST = 5'(STEPS - 1);

    cord_t      x_reg, y_reg, z_reg;
    logic [4:0] step_reg;
    logic       busy_reg;
    logic       done_reg;

    cord_t z_in, z_fold, x_fold;
    cord_t xs, ys, ang;

    // Fold the phase into the right half plane by half a turn.
    always_comb begin
        z_in   = {{(CORD_W-32){phase[31]}}, phase};
        z_fold = z_in;
        x_fold = CORDIC_GAIN;
        if (z_in > QUARTER_TURN || z_in < -QUARTER_TURN) begin
            x_fold = -CORDIC_GAIN;
            z_fold = (z_in > 0) ? z_in - HALF_TURN : z_in + HALF_TURN;
        end
        xs  = x_reg >>> step_reg;
        ys  = y_reg >>> step_reg;
        ang = {{(CORD_W-32){1'b0}}, angle_turns(step_reg)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x_fold;
            y_reg <= '0;
            z_reg <= z_fold;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
        end
    end

    assign done  = done_reg;
    assign cos_o = x_reg;
    assign sin_o = y_reg;

endmodule

// ----- hw/rtl/rvba_store.sv -----
module rvba_store #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12,
    parameter int unsigned DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata_re,
    input  logic [DW-1:0] wdata_im,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata_re,
    output logic [DW-1:0] rdata_im
);

    logic [DW-1:0] amp_real_mem [DEPTH];
    logic [DW-1:0] amp_imag_mem [DEPTH];
    logic [DW-1:0] rd_re_reg;
    logic [DW-1:0] rd_im_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            amp_real_mem[waddr] <= wdata_re;
            amp_imag_mem[waddr] <= wdata_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_re_reg <= amp_real_mem[raddr];
            rd_im_reg <= amp_imag_mem[raddr];
        end
    end

    assign rdata_re = rd_re_reg;
    assign rdata_im = rd_im_reg;

endmodule

// ----- hw/rtl/ray_voxel_binning_accumulator_unit.sv -----
// Channel   Ports           Payload (lowest bit first)
// --------  --------------  -----------------------------------------------------------
// input     s_t*            tdata: pos_x, pos_y, pos_z, ray_flux, path_length,
//                                  wavelength, voxel_addr; tuser: func
// result    m_t*            tdata: intensity; tuser: in_grid, mode_error
// config    APB p*          64-bit registers at byte address 8 * index
//
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
// After an input transfer, a coherent ray also runs the two-bit divider, the CORDIC
// and the flux scaling that an incoherent ray skips; a ray that misses the grid
// stops early, and a clear or no-op goes straight from dispatch to the final state.
// The block returns to idle before it accepts the next transfer. The shared 33x33
// multiplier is used for the nine matrix products, the flux scaling and the read
// squares. A stalled result holds the final state.
// After reset the voxel store is zeroed, one entry a cycle, before the first
// transfer is accepted.
module ray_voxel_binning_accumulator_unit #(
    parameter int unsigned VOXELS       = 4096,
    parameter int unsigned ACC_WIDTH    = 32,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [5:0]                       paddr,
    input  logic [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, pos_z, ray_flux, path_length, wavelength, voxel_addr, zero pad
    input  logic [rvba_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // intensity, zero pad
    output logic [rvba_pkg::M_TDATA_W-1:0]   m_tdata,
    // in_grid, mode_error
    output logic [1:0]                       m_tuser
);
    import rvba_pkg::*;

    localparam int unsigned AW      = (VOXELS > 1) ? $clog2(VOXELS) : 1;
    localparam int unsigned LOC_W   = 47;
    localparam int unsigned LIN_W   = 22;
    localparam int unsigned CON_W   = 20;
    localparam int unsigned SUM_W   = ACC_WIDTH + 21;
    localparam logic [AW-1:0]    CLR_LAST = AW'(VOXELS - 1);
    localparam logic [LIN_W-1:0] VOX_LIM  = LIN_W'(VOXELS);
    localparam logic [16:0]      VOX_LIM_A = 17'(VOXELS);
    localparam logic signed [SUM_W-1:0] ACC_HI =
        {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;
    localparam logic signed [LOC_W-1:0] LOC_HALF = LOC_W'(1 << 24);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << 29);

    localparam logic [4:0] ST_CLR  = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_DISP = 5'd2;
    localparam logic [4:0] ST_LOC  = 5'd3;
    localparam logic [4:0] ST_LCHK = 5'd4;
    localparam logic [4:0] ST_AD1  = 5'd5;
    localparam logic [4:0] ST_AD2  = 5'd6;
    localparam logic [4:0] ST_AD3  = 5'd7;
    localparam logic [4:0] ST_DIV  = 5'd8;
    localparam logic [4:0] ST_CORD = 5'd9;
    localparam logic [4:0] ST_CM1  = 5'd10;
    localparam logic [4:0] ST_CM2  = 5'd11;
    localparam logic [4:0] ST_CM3  = 5'd12;
    localparam logic [4:0] ST_RD   = 5'd13;
    localparam logic [4:0] ST_UPD  = 5'd14;
    localparam logic [4:0] ST_SQ1  = 5'd15;
    localparam logic [4:0] ST_SQ2  = 5'd16;
    localparam logic [4:0] ST_SQ3  = 5'd17;
    localparam logic [4:0] ST_FIN  = 5'd18;

    // Configuration registers
    logic [1:0]  mode_reg;
    logic [20:0] dims_reg;
    logic [62:0] offset_reg;
    logic [62:0] row_x_reg, row_y_reg, row_z_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            dims_reg   <= '0;
            offset_reg <= '0;
            row_x_reg  <= '0;
            row_y_reg  <= '0;
            row_z_reg  <= '0;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_MODE:   mode_reg   <= pwdata[1:0];
                REG_DIMS:   dims_reg   <= pwdata[20:0];
                REG_OFFSET: offset_reg <= pwdata[62:0];
                REG_ROW_X:  row_x_reg  <= pwdata[62:0];
                REG_ROW_Y:  row_y_reg  <= pwdata[62:0];
                REG_ROW_Z:  row_z_reg  <= pwdata[62:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_MODE:   prdata = {62'd0, mode_reg};
            REG_DIMS:   prdata = {43'd0, dims_reg};
            REG_OFFSET: prdata = {1'b0, offset_reg};
            REG_ROW_X:  prdata = {1'b0, row_x_reg};
            REG_ROW_Y:  prdata = {1'b0, row_y_reg};
            REG_ROW_Z:  prdata = {1'b0, row_z_reg};
            default:    prdata = '0;
        endcase
    end

    // Sequencer and item registers
    logic [4:0]               state_reg, state_next;
    logic [AW-1:0]            clr_cnt_reg;
    logic [1:0]               func_reg;
    logic [FLUX_W-1:0]        flux_reg;
    logic [OPL_W-1:0]         opl_reg;
    logic [LAM_W-1:0]         lam_reg;
    logic [VADDR_W-1:0]       vaddr_reg;
    logic signed [DIFF_W-1:0] d_reg [3];
    logic [1:0]               row_idx_reg, col_reg;
    logic signed [LOC_W-1:0]  acc_reg;
    logic [DIM_W-1:0]         idx_reg [3];
    logic [14:0]              part_reg;
    logic [13:0]              nxy_reg;
    logic [LIN_W-1:0]         lin_reg;
    logic [AW-1:0]            addr_reg;
    logic signed [CON_W-1:0]  con_re_reg, con_im_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [INT_W-1:0]         a2_reg;
    logic [INT_W-1:0]         res_int_reg;
    logic                     res_hit_reg;
    logic                     err_reg;
    logic                     big_re_reg, big_im_reg;
    logic                     m_valid_reg;
    logic [INT_W-1:0]         m_int_reg;
    logic                     m_hit_reg, m_err_reg;

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Unit handshakes
    logic        div_start, div_done, cord_done;
    logic [31:0] phase;
    cord_t       cos_v, sin_v;

    rvba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (opl_reg),
        .divisor  (lam_reg),
        .done     (div_done),
        .quotient (phase)
    );

    rvba_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_done),
        .phase   (phase),
        .done    (cord_done),
        .cos_o   (cos_v),
        .sin_o   (sin_v)
    );

    assign div_start = (state_reg == ST_AD3) && (lin_reg < VOX_LIM) && (mode_reg == MODE_COH);

    // Voxel store
    logic                 st_we, st_re;
    logic [AW-1:0]        st_waddr;
    logic [ACC_WIDTH-1:0] st_wre, st_wim, rd_re, rd_im;

    rvba_store #(.DEPTH(VOXELS), .AW(AW), .DW(ACC_WIDTH)) u_store (
        .aclk     (aclk),
        .we       (st_we),
        .waddr    (st_waddr),
        .wdata_re (st_wre),
        .wdata_im (st_wim),
        .re       (st_re),
        .raddr    (addr_reg),
        .rdata_re (rd_re),
        .rdata_im (rd_im)
    );

    // Saturating accumulate of the read-back voxel
    logic signed [SUM_W-1:0] sum_re, sum_im;
    logic [ACC_WIDTH-1:0]    sat_re, sat_im;
    always_comb begin
        sum_re = SUM_W'($signed(rd_re)) + SUM_W'(con_re_reg);
        sum_im = SUM_W'($signed(rd_im)) + SUM_W'(con_im_reg);
        if (sum_re > ACC_HI)      sat_re = ACC_HI[ACC_WIDTH-1:0];
        else if (sum_re < ACC_LO) sat_re = ACC_LO[ACC_WIDTH-1:0];
        else                      sat_re = sum_re[ACC_WIDTH-1:0];
        if (sum_im > ACC_HI)      sat_im = ACC_HI[ACC_WIDTH-1:0];
        else if (sum_im < ACC_LO) sat_im = ACC_LO[ACC_WIDTH-1:0];
        else                      sat_im = sum_im[ACC_WIDTH-1:0];
    end

    logic vaddr_ok;
    assign vaddr_ok = ({5'd0, vaddr_reg} < VOX_LIM_A);

    always_comb begin
        st_we    = 1'b0;
        st_waddr = addr_reg;
        st_wre   = '0;
        st_wim   = '0;
        case (state_reg)
            ST_CLR: begin
                st_we    = 1'b1;
                st_waddr = clr_cnt_reg;
            end
            ST_DISP: begin
                st_we    = (func_reg == FUNC_CLEAR) && vaddr_ok;
                st_waddr = AW'(vaddr_reg);
            end
            ST_UPD: begin
                st_we  = 1'b1;
                st_wre = sat_re;
                st_wim = sat_im;
            end
            default: ;
        endcase
    end
    assign st_re = (state_reg == ST_RD);

    // Magnitudes of the read-back voxel for squaring
    logic signed [48:0] re_s, im_s;
    logic [48:0]        re_m, im_m;
    always_comb begin
        re_s = 49'($signed(rd_re));
        im_s = 49'($signed(rd_im));
        re_m = re_s[48] ? 49'(-re_s) : re_s;
        im_m = im_s[48] ? 49'(-im_s) : im_s;
    end

    // Shared multiplier operand selection
    logic [62:0]        row_sel;
    logic [20:0]        row_fld;
    mul_op_t            mul_a, mul_b;
    always_comb begin
        case (row_idx_reg)
            2'd0:    row_sel = row_x_reg;
            2'd1:    row_sel = row_y_reg;
            default: row_sel = row_z_reg;
        endcase
        case (col_reg)
            2'd0:    row_fld = row_sel[20:0];
            2'd1:    row_fld = row_sel[41:21];
            default: row_fld = row_sel[62:42];
        endcase
        mul_a = MUL_W'($signed(row_fld));
        mul_b = MUL_W'(d_reg[col_reg]);
        case (state_reg)
            ST_CM1: begin
                mul_a = cos_v[MUL_W-1:0];
                mul_b = {{(MUL_W-FLUX_W){1'b0}}, flux_reg};
            end
            ST_CM2: begin
                mul_a = sin_v[MUL_W-1:0];
                mul_b = {{(MUL_W-FLUX_W){1'b0}}, flux_reg};
            end
            ST_SQ1: begin
                mul_a = {1'b0, re_m[31:0]};
                mul_b = {1'b0, re_m[31:0]};
            end
            ST_SQ2: begin
                mul_a = {1'b0, im_m[31:0]};
                mul_b = {1'b0, im_m[31:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Row check and rounding helpers
    logic signed [LOC_W-1:0]  loc_total;
    logic [DIM_W-1:0]         n_sel;
    logic signed [PROD_W-1:0] rnd;
    logic [INT_W-1:0]         sq_cap;
    logic [INT_W:0]           sq_sum;
    always_comb begin
        loc_total = acc_reg + prod_reg[LOC_W-1:0] + LOC_HALF;
        case (row_idx_reg)
            2'd0:    n_sel = dims_reg[6:0];
            2'd1:    n_sel = dims_reg[13:7];
            default: n_sel = dims_reg[20:14];
        endcase
        rnd = (prod_reg + RND_HALF) >>> 30;
        // Squares above the output range clamp to its maximum.
        if ((state_reg == ST_SQ2 && big_re_reg) || (state_reg == ST_SQ3 && big_im_reg)
                || prod_reg[PROD_W-1:INT_W] != '0) begin
            sq_cap = OUT_MAX;
        end else begin
            sq_cap = prod_reg[INT_W-1:0];
        end
        sq_sum = {1'b0, a2_reg} + {1'b0, sq_cap};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:  if (clr_cnt_reg == CLR_LAST) state_next = ST_IDLE;
            ST_IDLE: if (accept) state_next = ST_DISP;
            ST_DISP: begin
                state_next = ST_FIN;
                if (func_reg == FUNC_RAY && mode_reg < 2'd2) begin
                    state_next = ST_LOC;
                end else if (func_reg == FUNC_READ && mode_reg < 2'd2 && vaddr_ok) begin
                    state_next = ST_RD;
                end
            end
            ST_LOC:  if (col_reg == 2'd2) state_next = ST_LCHK;
            ST_LCHK: begin
                if (loc_total < 0 || loc_total[LOC_W-1:25] >= {15'd0, n_sel}) begin
                    state_next = ST_FIN;
                end else if (row_idx_reg == 2'd2) begin
                    state_next = ST_AD1;
                end else begin
                    state_next = ST_LOC;
                end
            end
            ST_AD1:  state_next = ST_AD2;
            ST_AD2:  state_next = ST_AD3;
            ST_AD3: begin
                if (lin_reg >= VOX_LIM)        state_next = ST_FIN;
                else if (mode_reg == MODE_COH) state_next = ST_DIV;
                else                           state_next = ST_RD;
            end
            ST_DIV:  if (div_done) state_next = ST_CORD;
            ST_CORD: if (cord_done) state_next = ST_CM1;
            ST_CM1:  state_next = ST_CM2;
            ST_CM2:  state_next = ST_CM3;
            ST_CM3:  state_next = ST_RD;
            ST_RD:   state_next = (func_reg == FUNC_RAY) ? ST_UPD : ST_SQ1;
            ST_UPD:  state_next = ST_FIN;
            ST_SQ1:  state_next = (mode_reg == MODE_INCOH) ? ST_FIN : ST_SQ2;
            ST_SQ2:  state_next = ST_SQ3;
            ST_SQ3:  state_next = ST_FIN;
            ST_FIN:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == ST_FIN && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= s_tuser;
            flux_reg  <= s_tdata[FLUX_LO +: FLUX_W];
            opl_reg   <= s_tdata[OPL_LO +: OPL_W];
            lam_reg   <= s_tdata[LAM_LO +: LAM_W];
            vaddr_reg <= s_tdata[VADDR_LO +: VADDR_W];
            d_reg[0]  <= DIFF_W'($signed(s_tdata[POS_X_LO +: COORD_W]))
                       - DIFF_W'($signed(offset_reg[20:0]));
            d_reg[1]  <= DIFF_W'($signed(s_tdata[POS_Y_LO +: COORD_W]))
                       - DIFF_W'($signed(offset_reg[41:21]));
            d_reg[2]  <= DIFF_W'($signed(s_tdata[POS_Z_LO +: COORD_W]))
                       - DIFF_W'($signed(offset_reg[62:42]));
        end
        case (state_reg)
            ST_DISP: begin
                err_reg     <= (mode_reg >= 2'd2);
                res_int_reg <= '0;
                res_hit_reg <= 1'b0;
                row_idx_reg <= '0;
                col_reg     <= '0;
                addr_reg    <= AW'(vaddr_reg);
            end
            ST_LOC: begin
                col_reg <= (col_reg == 2'd2) ? 2'd0 : col_reg + 2'd1;
                case (col_reg)
                    2'd0:    acc_reg <= '0;
                    2'd1:    acc_reg <= prod_reg[LOC_W-1:0];
                    default: acc_reg <= acc_reg + prod_reg[LOC_W-1:0];
                endcase
            end
            ST_LCHK: begin
                idx_reg[row_idx_reg] <= loc_total[25 +: DIM_W];
                row_idx_reg          <= row_idx_reg + 2'd1;
                col_reg              <= '0;
            end
            ST_AD1: begin
                part_reg <= 15'(idx_reg[0]) + 15'(idx_reg[1]) * 15'(dims_reg[6:0]);
                nxy_reg  <= 14'(dims_reg[6:0]) * 14'(dims_reg[13:7]);
            end
            ST_AD2: begin
                lin_reg <= LIN_W'(part_reg) + LIN_W'(idx_reg[2]) * LIN_W'(nxy_reg);
            end
            ST_AD3: begin
                addr_reg   <= lin_reg[AW-1:0];
                con_re_reg <= CON_W'(flux_reg);
                con_im_reg <= '0;
            end
            ST_CM2:  con_re_reg <= rnd[CON_W-1:0];
            ST_CM3:  con_im_reg <= rnd[CON_W-1:0];
            ST_UPD:  res_hit_reg <= 1'b1;
            ST_SQ1: begin
                big_re_reg <= (re_m[48:32] != '0);
                big_im_reg <= (im_m[48:32] != '0);
                if ($signed(rd_re) > 0) begin
                    res_int_reg <= INT_W'(rd_re);
                end
            end
            ST_SQ2:  a2_reg <= sq_cap;
            ST_SQ3:  res_int_reg <= sq_sum[INT_W] ? OUT_MAX : sq_sum[INT_W-1:0];
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_int_reg <= res_int_reg;
                    m_hit_reg <= res_hit_reg;
                    m_err_reg <= err_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_int_reg};
    assign m_tuser  = {m_err_reg, m_hit_reg};

endmodule

// ----- hw/rtl/rvba_checker.sv -----
module rvba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A result waiting for its transfer keeps its payload.
    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    // A ray is never added while the mode is unsupported.
    property p_err_no_hit;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid |-> !(m_tuser[0] && m_tuser[1]);
    endproperty
    a_err_no_hit: assert property (p_err_no_hit) else $error("hit flagged with mode error");

    // A binned ray carries no intensity.
    property p_hit_zero;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid && m_tuser[0] |-> m_tdata == 64'd0;
    endproperty
    a_hit_zero: assert property (p_hit_zero) else $error("ray result with intensity");

    // The store is being zeroed right after reset.
    property p_reset_busy;
        @(posedge aclk) !aresetn |=> !s_tready;
    endproperty
    a_reset_busy: assert property (p_reset_busy) else $error("ready during clearing pass");

    // One item at a time: ready drops after every input transfer.
    property p_one_item;
        @(posedge aclk) disable iff (!aresetn)
            s_tvalid && s_tready |=> !s_tready;
    endproperty
    a_one_item: assert property (p_one_item) else $error("second item taken while busy");

endmodule

bind ray_voxel_binning_accumulator_unit rvba_checker u_rvba_checker (.*);

// ----- dv/ray_voxel_binning_accumulator_unit_test.sv -----
`timescale 1ns / 1ps

typedef struct {
    logic [1:0]         func;
    logic signed [20:0] pos_x;
    logic signed [20:0] pos_y;
    logic signed [20:0] pos_z;
    logic [15:0]        flux;
    logic [31:0]        opl;
    logic [15:0]        lam;
    logic [11:0]        vaddr;
} ray_item_t;

typedef struct {
    logic [62:0] intensity;
    logic        in_grid;
    logic        mode_error;
} voxel_result_t;

class voxel_scoreboard;
    localparam int NVOX  = 4096;
    localparam int STEPS = 16;
    localparam longint ACC_HI = 64'sd2147483647;
    localparam longint ACC_LO = -64'sd2147483648;
    localparam logic [62:0] SAT63 = '1;

    longint amp_re[NVOX];
    longint amp_im[NVOX];
    logic [1:0]  mode;
    logic [20:0] dims;
    logic [62:0] offset;
    logic [62:0] rows[3];
    voxel_result_t pending_q[$];
    int errors;
    int results_seen;
    int hits_seen;
    longint atan_tab[STEPS];

    function new();
        atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                     64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                     64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                     64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
        foreach (amp_re[i]) begin
            amp_re[i] = 0;
            amp_im[i] = 0;
        end
        mode = 0;
        dims = 0;
        offset = 0;
        rows = '{63'd0, 63'd0, 63'd0};
        errors = 0;
        results_seen = 0;
        hits_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            rvba_pkg::REG_MODE:   mode = val[1:0];
            rvba_pkg::REG_DIMS:   dims = val[20:0];
            rvba_pkg::REG_OFFSET: offset = val[62:0];
            rvba_pkg::REG_ROW_X:  rows[0] = val[62:0];
            rvba_pkg::REG_ROW_Y:  rows[1] = val[62:0];
            rvba_pkg::REG_ROW_Z:  rows[2] = val[62:0];
            default: ;
        endcase
    endfunction

    function longint sx21(logic [20:0] v);
        return longint'($signed(v));
    endfunction

    function longint sat_acc(longint a, longint b);
        longint s;
        s = a + b;
        if (s > ACC_HI) return ACC_HI;
        if (s < ACC_LO) return ACC_LO;
        return s;
    endfunction

    function longint unsigned square_sat(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        if (m > 64'hFFFFFFFF) return {1'b0, SAT63};
        m = m * m;
        return (m > {1'b0, SAT63}) ? {1'b0, SAT63} : m;
    endfunction

    // Voxel address of a ray, or -1 when it falls outside the grid.
    function longint voxel_of(ray_item_t it);
        longint n[3];
        longint d[3];
        longint ix[3];
        longint acc;
        longint unsigned a;
        n[0] = dims[6:0];
        n[1] = dims[13:7];
        n[2] = dims[20:14];
        d[0] = longint'(it.pos_x) - sx21(offset[20:0]);
        d[1] = longint'(it.pos_y) - sx21(offset[41:21]);
        d[2] = longint'(it.pos_z) - sx21(offset[62:42]);
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += sx21(rows[r][21*k +: 21]) * d[k];
            acc += 64'sd1 << 24;
            if (acc < 0) return -1;
            ix[r] = acc >>> 25;
            if (ix[r] >= n[r]) return -1;
        end
        a = ix[0] + ix[1] * n[0] + ix[2] * n[0] * n[1];
        if (a >= NVOX) return -1;
        return longint'(a);
    endfunction

    function void unit_phasor(longint unsigned opl, longint unsigned lam,
                              output longint c, output longint s);
        longint unsigned p;
        longint x, y, z, xs, ys;
        p = 0;
        x = longint'(rvba_pkg::CORDIC_GAIN);
        y = 0;
        if (lam != 0)
            p = ((opl % lam) << 32) / lam;
        z = longint'(p);
        if (z >= (64'sd1 << 31)) z -= 64'sd1 << 32;
        // Fold the outer half turn onto the CORDIC's convergence range.
        if (z > (64'sd1 << 30) || z < -(64'sd1 << 30)) begin
            x = -x;
            z += (z > 0) ? -(64'sd1 << 31) : (64'sd1 << 31);
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function void note_item(ray_item_t it);
        voxel_result_t r;
        longint a, fl, c, s;
        longint unsigned q, b;
        logic err;
        err = (mode >= 2);
        r.intensity = 0;
        r.in_grid = 0;
        r.mode_error = err;
        if (it.func == rvba_pkg::FUNC_RAY && !err) begin
            a = voxel_of(it);
            if (a >= 0) begin
                fl = it.flux;
                if (mode == rvba_pkg::MODE_INCOH) begin
                    amp_re[a] = sat_acc(amp_re[a], fl);
                end else begin
                    unit_phasor(it.opl, it.lam, c, s);
                    amp_re[a] = sat_acc(amp_re[a], (fl * c + (64'sd1 << 29)) >>> 30);
                    amp_im[a] = sat_acc(amp_im[a], (fl * s + (64'sd1 << 29)) >>> 30);
                end
                r.in_grid = 1;
            end
        end else if (it.func == rvba_pkg::FUNC_READ && !err) begin
            if (mode == rvba_pkg::MODE_INCOH) begin
                r.intensity = (amp_re[it.vaddr] > 0) ? amp_re[it.vaddr][62:0] : 63'd0;
            end else begin
                q = square_sat(amp_re[it.vaddr]);
                b = square_sat(amp_im[it.vaddr]);
                r.intensity = (q > {1'b0, SAT63} - b) ? SAT63 : 63'(q + b);
            end
        end else if (it.func == rvba_pkg::FUNC_CLEAR) begin
            amp_re[it.vaddr] = 0;
            amp_im[it.vaddr] = 0;
        end
        pending_q.push_back(r);
    endfunction

    function void check(logic [63:0] td, logic [1:0] tu);
        voxel_result_t e;
        results_seen++;
        if (pending_q.size() == 0) begin
            $error("result transfer with no expectation: intensity %0h", td[62:0]);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (tu[0]) hits_seen++;
        if (td[62:0] !== e.intensity) begin
            $error("intensity: expected %0h, got %0h", e.intensity, td[62:0]);
            errors++;
        end
        if (tu[0] !== e.in_grid) begin
            $error("in_grid: expected %0b, got %0b", e.in_grid, tu[0]);
            errors++;
        end
        if (tu[1] !== e.mode_error) begin
            $error("mode_error: expected %0b, got %0b", e.mode_error, tu[1]);
            errors++;
        end
    endfunction

    function int pending();
        return pending_q.size();
    endfunction
endclass

module ray_voxel_binning_accumulator_unit_test;
    import rvba_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [20:0] DIAG_ONE  = 21'd32768;
    localparam logic [20:0] DIAG_HALF = 21'd16384;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    // pos_x, pos_y, pos_z, ray_flux, path_length, wavelength, voxel_addr, zero pad
    logic [S_TDATA_W-1:0] s_tdata;
    // func
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // intensity, zero pad
    logic [M_TDATA_W-1:0] m_tdata;
    // in_grid, mode_error
    logic [1:0]  m_tuser;

    voxel_scoreboard sb;
    longint cycles;
    bit quiet;
    int items_sent;
    int stall_left;

    // Grid of the current phase, used to aim rays at voxels.
    int gn[3];
    int unit_len;
    logic signed [20:0] goff[3];

    ray_voxel_binning_accumulator_unit dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL ray_voxel_binning_accumulator_unit");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = gap_len();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
    end

    task automatic apb_write(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 3'b000}; pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic send_item(ray_item_t it);
        int g;
        g = gap_len();
        @(negedge aclk);
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata = '0;
        s_tdata[POS_X_LO +: COORD_W] = it.pos_x;
        s_tdata[POS_Y_LO +: COORD_W] = it.pos_y;
        s_tdata[POS_Z_LO +: COORD_W] = it.pos_z;
        s_tdata[FLUX_LO  +: FLUX_W]  = it.flux;
        s_tdata[OPL_LO   +: OPL_W]   = it.opl;
        s_tdata[LAM_LO   +: LAM_W]   = it.lam;
        s_tdata[VADDR_LO +: VADDR_W] = it.vaddr;
        s_tuser = it.func;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(it);
        items_sent++;
    endtask

    // The last item has been taken, so valid drops before the block is ready again.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    // Sets mode, grid, an offset of up to off_span and a scaled identity matrix, and remembers the grid.
    task automatic set_grid(logic [1:0] md, int nx, int ny, int nz,
                            logic [20:0] diag, int off_span);
        for (int k = 0; k < 3; k++)
            goff[k] = 21'($signed($urandom_range(0, 2 * off_span)) - off_span);
        gn = '{nx, ny, nz};
        unit_len = (diag == DIAG_HALF) ? 2048 : 1024;
        apb_write(REG_MODE, {62'd0, md});
        apb_write(REG_DIMS, {43'd0, 7'(nz), 7'(ny), 7'(nx)});
        apb_write(REG_OFFSET, {1'b0, goff[2], goff[1], goff[0]});
        apb_write(REG_ROW_X, {43'd0, diag});
        apb_write(REG_ROW_Y, {22'd0, diag, 21'd0});
        apb_write(REG_ROW_Z, {1'b0, diag, 42'd0});
    endtask

    function automatic logic signed [20:0] aim(int k);
        int ix, fr;
        ix = (gn[k] > 0) ? $urandom_range(0, gn[k] - 1) : 0;
        // Now and then land just past an edge of the grid.
        if ($urandom_range(0, 19) == 0) ix = ($urandom_range(0, 1) == 1) ? gn[k] : -1;
        fr = $urandom_range(0, unit_len - 2) - (unit_len / 2 - 1);
        return 21'(goff[k] + ix * unit_len + fr);
    endfunction

    function automatic ray_item_t rand_item();
        ray_item_t it;
        int r, span;
        r = $urandom_range(0, 99);
        span = gn[0] * gn[1] * gn[2];
        if (span < 1 || span > 4096) span = 4096;
        it.func  = FUNC_RAY;
        it.pos_x = 21'($urandom()); it.pos_y = 21'($urandom()); it.pos_z = 21'($urandom());
        it.opl   = $urandom();
        it.vaddr = 12'($urandom());
        case ($urandom_range(0, 9))
            0:       it.flux = 16'hFFFF;
            1:       it.flux = 16'h0000;
            default: it.flux = 16'($urandom());
        endcase
        case ($urandom_range(0, 19))
            0:       it.lam = 16'd0;
            1:       it.lam = 16'd1;
            2:       it.lam = 16'hFFFF;
            default: it.lam = 16'($urandom_range(1, 65535));
        endcase
        if (r < 60) begin
            it.pos_x = aim(0); it.pos_y = aim(1); it.pos_z = aim(2);
        end else if (r < 70) begin
            it.func = FUNC_RAY;
        end else if (r < 85) begin
            it.func = FUNC_READ;
            it.vaddr = 12'($urandom_range(0, span - 1));
        end else if (r < 93) begin
            it.func = FUNC_CLEAR;
            it.vaddr = 12'($urandom_range(0, span - 1));
        end else if (r < 97) begin
            it.func = FUNC_READ;
        end else begin
            it.func = FUNC_NOP;
        end
        return it;
    endfunction

    task automatic directed_items();
        ray_item_t it;
        it = '{FUNC_RAY, goff[0], goff[1], goff[2], 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 12'd0};
        send_item(it);
        it.lam = 16'd0;
        send_item(it);
        it.lam = 16'd1; it.flux = 16'd0;
        send_item(it);
        it.flux = 16'h8001; it.opl = 32'd3; it.lam = 16'd7;
        send_item(it);
        it.pos_x = 21'sh0FFFFF; it.pos_y = -21'sh100000; it.pos_z = 21'sh0FFFFF;
        send_item(it);
        it.pos_x = -21'sh100000; it.pos_y = 21'sh0FFFFF; it.pos_z = -21'sh100000;
        send_item(it);
        it.func = FUNC_READ; it.vaddr = 12'd0;
        send_item(it);
        it.vaddr = 12'hFFF;
        send_item(it);
        it.func = FUNC_CLEAR; it.vaddr = 12'd0;
        send_item(it);
        it.func = FUNC_READ;
        send_item(it);
        it.func = FUNC_CLEAR; it.vaddr = 12'hFFF;
        send_item(it);
        it.func = FUNC_NOP; it.vaddr = 12'h5A5;
        send_item(it);
    endtask

    task automatic random_items(int count);
        repeat (count) send_item(rand_item());
    endtask

    initial begin
        sb = new();
        cycles = 0;
        quiet = 0;
        items_sent = 0;
        stall_left = 0;
        gn = '{0, 0, 0};
        unit_len = 1024;
        goff = '{21'sd0, 21'sd0, 21'sd0};
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = FUNC_NOP;
        m_tready = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_grid(MODE_INCOH, 4, 4, 4, DIAG_ONE, 0);
        directed_items();
        random_items(100);
        drain();

        set_grid(MODE_COH, 8, 8, 8, DIAG_ONE, 4000);
        directed_items();
        quiet = 1;
        random_items(60);
        quiet = 0;
        random_items(90);
        drain();

        // Coherent sums with a negative real part read back as zero here.
        apb_write(REG_MODE, {62'd0, MODE_INCOH});
        random_items(90);
        drain();

        apb_write(REG_MODE, 64'd2);
        directed_items();
        random_items(40);
        drain();
        apb_write(REG_MODE, 64'd3);
        apb_write(REG_UNUSED, {$urandom(), $urandom()});
        random_items(40);
        drain();

        set_grid(MODE_COH, 127, 127, 127, DIAG_HALF, 100000);
        random_items(110);
        drain();

        set_grid(MODE_INCOH, 0, 0, 0, DIAG_ONE, 0);
        random_items(40);
        drain();

        // Arbitrary matrix and offset: mostly rays that miss.
        apb_write(REG_MODE, {63'd0, 1'($urandom_range(0, 1))});
        apb_write(REG_DIMS, 64'h1FFFFF);
        apb_write(REG_OFFSET, {$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF_FFFF);
        apb_write(REG_ROW_X, 64'h7FFF_FFFF_FFFF_FFFF);
        apb_write(REG_ROW_Y, {$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF_FFFF);
        apb_write(REG_ROW_Z, {$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF_FFFF);
        gn = '{0, 0, 0};
        random_items(60);
        drain();

        set_grid(MODE_COH, 16, 16, 16, DIAG_ONE, 400000);
        random_items(130);
        drain();
        set_grid(MODE_INCOH, 16, 16, 16, DIAG_ONE, 0);
        random_items(150);

        @(negedge aclk);
        s_tvalid = 1'b0;
        drain();
        repeat (200) @(posedge aclk);
        $display("Sent %0d items over incoherent, coherent, unsupported and empty-grid phases;",
                 items_sent);
        $display("checked %0d results, %0d of them rays binned into a voxel.",
                 sb.results_seen, sb.hits_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS ray_voxel_binning_accumulator_unit");
        end else begin
            $display("FAIL ray_voxel_binning_accumulator_unit");
        end
        $finish;
    end
endmodule
